@@ design/crse_pkg.sv @@
// ----------------------------------------------------------------------------
// crse_pkg
// Shared types and constants of the checkerboard rectangle sum engine.
// ----------------------------------------------------------------------------
package crse_pkg;

   localparam int SUM_W   = 50;  // width of all prefix and rectangle sums
   localparam int COORD_W = 10;  // width of coordinates and of the side register
   localparam int CELL_W  = 32;  // width of the raw cell field

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_ERROR = 2'd2
   } op_type;

   // Control part of one command passed from the front end to the back end.
   typedef struct packed {
      op_type           op;
      logic [SUM_W-1:0] cell_value; // sign-extended cell, negated if row+col is even
      logic [3:0]       zero;       // table reads that stand for row 0 or column 0
      logic             left_zero;  // load starts a new row
   } cmd_ctrl_type;

endpackage

@@ design/crse_fifo.sv @@
// ----------------------------------------------------------------------------
// crse_fifo
// Small synchronous first-in first-out queue built from registers.
// ----------------------------------------------------------------------------
module crse_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/crse_front.sv @@
// ----------------------------------------------------------------------------
// crse_front
// Front end: accepts requests, tracks the load position and grid state,
// checks queries and turns each query and each accepted load into a table command.
// ----------------------------------------------------------------------------
module crse_front
   import crse_pkg::*;
#(
   parameter int MAX_SIDE   = 512,
   parameter int VALUE_BITS = 32,
   parameter int IDX_W      = 9,
   parameter int ADDR_W     = 18
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [COORD_W-1:0]     csr_wr_data,
   input  logic                   req_valid,
   input  logic                   req_type,
   input  logic [CELL_W-1:0]      req_cell_value,
   input  logic [COORD_W-1:0]     req_top_row,
   input  logic [COORD_W-1:0]     req_left_col,
   input  logic [COORD_W-1:0]     req_bottom_row,
   input  logic [COORD_W-1:0]     req_right_col,
   output logic                   cmd_push,
   output cmd_ctrl_type           cmd_ctrl,
   output logic [3:0][ADDR_W-1:0] cmd_addr
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);

   logic [SIDE_W-1:0]     side_ff, side_in;
   logic [SIDE_W-1:0]     row_ff, row_in;
   logic [SIDE_W-1:0]     col_ff, col_in;
   logic                  full_ff, full_in;
   logic [VALUE_BITS-1:0] raw_value;
   logic [SUM_W-1:0]      cell_ext;
   logic                  load_ok, query_ok;
   logic [31:0]           side32, row32, col32;
   logic [31:0]           top32, left32, bottom32, right32;

   function automatic logic [ADDR_W-1:0] table_addr(input logic [31:0] row,
                                                    input logic [31:0] col);
      logic [IDX_W-1:0] r_idx;
      logic [IDX_W-1:0] c_idx;
      r_idx = IDX_W'(row - 32'd1);
      c_idx = IDX_W'(col - 32'd1);
      return {r_idx, c_idx};
   endfunction

   assign side32   = 32'(side_ff);
   assign row32    = 32'(row_ff);
   assign col32    = 32'(col_ff);
   assign top32    = 32'(req_top_row);
   assign left32   = 32'(req_left_col);
   assign bottom32 = 32'(req_bottom_row);
   assign right32  = 32'(req_right_col);

   assign raw_value = req_cell_value[VALUE_BITS-1:0];
   assign cell_ext  = {{(SUM_W - VALUE_BITS){raw_value[VALUE_BITS-1]}}, raw_value};

   assign load_ok  = !full_ff && (row32 <= side32) && (col32 <= side32);
   assign query_ok = full_ff && (top32 >= 32'd1) && (left32 >= 32'd1)
                     && (top32 <= bottom32) && (left32 <= right32)
                     && (bottom32 <= side32) && (right32 <= side32);

   always_comb begin
      side_in  = side_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      full_in  = full_ff;
      cmd_push = 1'b0;
      cmd_ctrl = '{op: OP_ERROR, cell_value: '0, zero: '0, left_zero: 1'b0};
      cmd_addr = '0;

      if (csr_wr_en) begin
         // Out-of-range sides are clamped once, here, at write time.
         if (csr_wr_data == '0) begin
            side_in = SIDE_W'(1);
         end else if (32'(csr_wr_data) > 32'(MAX_SIDE)) begin
            side_in = SIDE_W'(MAX_SIDE);
         end else begin
            side_in = SIDE_W'(csr_wr_data);
         end
         row_in  = SIDE_W'(1);
         col_in  = SIDE_W'(1);
         full_in = 1'b0;
      end else if (req_valid && !req_type) begin
         if (load_ok) begin
            cmd_push            = 1'b1;
            cmd_ctrl.op         = OP_LOAD;
            // Cells whose row plus column is even enter with negated sign.
            cmd_ctrl.cell_value = (row_ff[0] == col_ff[0]) ? SUM_W'(0) - cell_ext
                                                           : cell_ext;
            cmd_ctrl.zero[0]    = (row32 == 32'd1);
            cmd_ctrl.zero[1]    = (row32 == 32'd1) || (col32 == 32'd1);
            cmd_ctrl.left_zero  = (col32 == 32'd1);
            cmd_addr[0]         = table_addr(row32 - 32'd1, col32);
            cmd_addr[1]         = table_addr(row32 - 32'd1, col32 - 32'd1);
            cmd_addr[2]         = table_addr(row32, col32);
            if (col32 >= side32) begin
               col_in = SIDE_W'(1);
               if (row32 >= side32) begin
                  row_in  = SIDE_W'(1);
                  full_in = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end else if (req_valid) begin
         cmd_push = 1'b1;
         if (query_ok) begin
            cmd_ctrl.op      = OP_QUERY;
            cmd_ctrl.zero[1] = (top32 == 32'd1);
            cmd_ctrl.zero[2] = (left32 == 32'd1);
            cmd_ctrl.zero[3] = (top32 == 32'd1) || (left32 == 32'd1);
            cmd_addr[0]      = table_addr(bottom32, right32);
            cmd_addr[1]      = table_addr(top32 - 32'd1, right32);
            cmd_addr[2]      = table_addr(bottom32, left32 - 32'd1);
            cmd_addr[3]      = table_addr(top32 - 32'd1, left32 - 32'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_W'(1);
         row_ff  <= SIDE_W'(1);
         col_ff  <= SIDE_W'(1);
         full_ff <= 1'b0;
      end else begin
         side_ff <= side_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         full_ff <= full_in;
      end
   end

endmodule

@@ design/crse_back.sv @@
// ----------------------------------------------------------------------------
// crse_back
// Back end: runs table commands against the single-port prefix table, at
// most one table access per cycle, and forms query results.
// ----------------------------------------------------------------------------
module crse_back
   import crse_pkg::*;
#(
   parameter int ADDR_W = 18
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  cmd_ctrl_type           cmd_ctrl,
   input  logic [3:0][ADDR_W-1:0] cmd_addr,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output logic [SUM_W-1:0]       rsp_mag,
   output logic                   rsp_status
);

   localparam int DEPTH = 2 ** ADDR_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   cmd_ctrl_type           ctrl_ff, ctrl_in;
   logic [3:0][ADDR_W-1:0] addr_ff, addr_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic [SUM_W-1:0]       left_ff, left_in;
   logic [1:0]             step_ff, step_in;
   logic                   rdv_ff, rdv_in;
   logic [1:0]             rdk_ff, rdk_in;
   logic [SUM_W-1:0]       rdata_ff;
   logic [SUM_W-1:0]       term;
   logic [1:0]             last_step;
   logic                   mem_re, mem_we;
   logic [ADDR_W-1:0]      mem_addr;

   logic [SUM_W-1:0] table_mem [DEPTH];

   assign last_step = (ctrl_ff.op == OP_LOAD) ? 2'd1 : 2'd3;
   assign term      = ctrl_ff.zero[rdk_ff] ? '0 : rdata_ff;
   assign rsp_mag   = acc_ff[SUM_W-1] ? SUM_W'(0) - acc_ff : acc_ff;
   assign rsp_status = (ctrl_ff.op == OP_ERROR);

   always_comb begin
      state_in = state_ff;
      ctrl_in  = ctrl_ff;
      addr_in  = addr_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      step_in  = step_ff;
      rdv_in   = 1'b0;
      rdk_in   = rdk_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      mem_re   = 1'b0;
      mem_we   = 1'b0;
      mem_addr = addr_ff[step_ff];

      // Read data arrives in the cycle after its address; reads 0 and 3 add,
      // reads 1 and 2 subtract.
      if (rdv_ff) begin
         if (rdk_ff == 2'd0 || rdk_ff == 2'd3) begin
            acc_in = acc_ff + term;
         end else begin
            acc_in = acc_ff - term;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               ctrl_in = cmd_ctrl;
               addr_in = cmd_addr;
               step_in = 2'd0;
               if (cmd_ctrl.op == OP_LOAD) begin
                  acc_in = cmd_ctrl.cell_value
                           + (cmd_ctrl.left_zero ? SUM_W'(0) : left_ff);
               end else begin
                  acc_in = '0;
               end
               state_in = (cmd_ctrl.op == OP_QUERY || cmd_ctrl.op == OP_LOAD) ?
                          ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            mem_re  = 1'b1;
            rdv_in  = 1'b1;
            rdk_in  = step_ff;
            step_in = step_ff + 1'b1;
            if (step_ff == last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctrl_ff.op == OP_LOAD) begin
               mem_we   = 1'b1;
               mem_addr = addr_ff[2];
               left_in  = acc_ff;
               state_in = ST_IDLE;
            end else if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rdv_ff   <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rdv_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      addr_ff <= addr_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      rdk_ff  <= rdk_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= acc_ff;
      end
      if (mem_re) begin
         rdata_ff <= table_mem[mem_addr];
      end
   end

endmodule

@@ design/checkerboard_rect_sum_engine.sv @@
// ----------------------------------------------------------------------------
// checkerboard_rect_sum_engine
// Checkerboard-signed two-dimensional prefix-sum table with rectangle queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full. A load request (req_type 0) stores the
//   next grid cell in row-major order; a query request (req_type 1) names an
//   inclusive rectangle and returns one result on the rsp_ side, which reads
//   like a queue: the oldest result is shown while empty is low and is taken
//   with pop. Loads return nothing.
//   csr_wr_en/csr_wr_data set the grid side and restart loading; write it
//   only while the block is idle.
//   Timing: the back end makes at most one single-port table access per cycle
//   and finishes each command before it takes the next. A load steps through
//   the states idle, read, drain and done (two reads, one write), a valid
//   query through the same states (four reads), and a rejected query goes
//   from idle straight to done. A result also waits behind earlier requests.
//   A four-entry command queue lets requests be taken while the back end is
//   busy; a two-entry result queue holds results while the receiver stalls,
//   and full rises when the command queue fills.
//   Reset clears the load position, the side (to 1) and both queues; the
//   table contents are kept and are rewritten by the next load pass.
// ----------------------------------------------------------------------------
module checkerboard_rect_sum_engine
   import crse_pkg::*;
#(
   parameter int MAX_SIDE   = 512,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COORD_W-1:0] csr_wr_data,
   input  logic               push,
   output logic               full,
   input  logic               req_type,
   input  logic [CELL_W-1:0]  req_cell_value,
   input  logic [COORD_W-1:0] req_top_row,
   input  logic [COORD_W-1:0] req_left_col,
   input  logic [COORD_W-1:0] req_bottom_row,
   input  logic [COORD_W-1:0] req_right_col,
   output logic               empty,
   input  logic               pop,
   output logic [SUM_W-1:0]   rsp_rect_magnitude,
   output logic               rsp_query_status
);

   localparam int IDX_W   = $clog2(MAX_SIDE);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int CMD_W   = $bits(cmd_ctrl_type) + 4 * ADDR_W;
   localparam int RSP_W   = SUM_W + 1;

   logic                   front_push;
   cmd_ctrl_type           front_ctrl;
   logic [3:0][ADDR_W-1:0] front_addr;
   logic                   cmd_full, cmd_empty, cmd_pop;
   logic [CMD_W-1:0]       cmd_data;
   cmd_ctrl_type           back_ctrl;
   logic [3:0][ADDR_W-1:0] back_addr;
   logic                   rsp_full, rsp_push;
   logic [SUM_W-1:0]       back_mag;
   logic                   back_status;
   logic [RSP_W-1:0]       rsp_data;

   assign full = cmd_full;
   assign {back_ctrl, back_addr} = cmd_data;
   assign {rsp_query_status, rsp_rect_magnitude} = rsp_data;

   crse_front #(
      .MAX_SIDE   (MAX_SIDE),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (push && !cmd_full),
      .req_type       (req_type),
      .req_cell_value (req_cell_value),
      .req_top_row    (req_top_row),
      .req_left_col   (req_left_col),
      .req_bottom_row (req_bottom_row),
      .req_right_col  (req_right_col),
      .cmd_push       (front_push),
      .cmd_ctrl       (front_ctrl),
      .cmd_addr       (front_addr)
   );

   crse_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (4)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data ({front_ctrl, front_addr}),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (cmd_empty)
   );

   crse_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_ctrl   (back_ctrl),
      .cmd_addr   (back_addr),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_mag    (back_mag),
      .rsp_status (back_status)
   );

   crse_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data ({back_status, back_mag}),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

@@ design/crse_checker.sv @@
// ----------------------------------------------------------------------------
// crse_checker
// Port-level checks of the checkerboard rectangle sum engine.
// ----------------------------------------------------------------------------
module crse_checker
   import crse_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input logic [SUM_W-1:0] rsp_rect_magnitude,
   input logic             rsp_query_status
);

   // Both queues come out of reset drained.
   a_reset_drains: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not drained after reset");

   // A rejected query always reports a zero magnitude.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_query_status) |-> (rsp_rect_magnitude == '0))
      else $error("error result with nonzero magnitude");

   // No magnitude exceeds half the sum range.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (!rsp_rect_magnitude[SUM_W-1]
                  || rsp_rect_magnitude[SUM_W-2:0] == '0))
      else $error("magnitude out of range");

   // A result that is not taken stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_rect_magnitude)
                            && $stable(rsp_query_status)))
      else $error("waiting result changed");

endmodule

bind checkerboard_rect_sum_engine crse_checker u_crse_checker (.*);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the checkerboard rectangle sum engine.
// ----------------------------------------------------------------------------
// Requests are pushed through the push/full side and results are drained
// through the empty/pop side, both with random idle bursts. A predictor in
// this file keeps its own prefix-sum table, load position and side register.
// It works out every query answer at the edge where the request is taken,
// and the result monitor compares each popped result with the oldest one.
// ----------------------------------------------------------------------------
module tb;
   import crse_pkg::*;

   localparam int GRID_MAX     = 512;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int STALL_LIMIT  = 4000;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [CELL_W-1:0] CELL_MIN = 32'h8000_0000;
   localparam logic [CELL_W-1:0] CELL_MAX = 32'h7fff_ffff;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SUM_W-1:0]   sum_type;

   typedef struct packed {
      sum_type magnitude;
      logic    status;
   } rect_result_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_wr_en      = 1'b0;
   logic [COORD_W-1:0] csr_wr_data    = '0;
   logic               push           = 1'b0;
   logic               full;
   logic               req_type       = 1'b0;
   logic [CELL_W-1:0]  req_cell_value = '0;
   coord_type          req_top_row    = '0;
   coord_type          req_left_col   = '0;
   coord_type          req_bottom_row = '0;
   coord_type          req_right_col  = '0;
   logic               empty;
   logic               pop            = 1'b0;
   sum_type            rsp_rect_magnitude;
   logic               rsp_query_status;

   // Predicted state of the block.
   bit [SUM_W-1:0]  prefix_sums [int unsigned];
   coord_type       side_reg;
   int unsigned     next_row;
   int unsigned     next_col;
   sum_type         run_sum;
   bit              grid_loaded;
   rect_result_type expected_rects [$];

   int  failures    = 0;
   int  idle_cycles = 0;
   bit  tx_idle_en  = 1'b1;
   bit  rx_idle_en  = 1'b1;
   bit  hold_wanted = 1'b0;

   checkerboard_rect_sum_engine u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_cell_value     (req_cell_value),
      .req_top_row        (req_top_row),
      .req_left_col       (req_left_col),
      .req_bottom_row     (req_bottom_row),
      .req_right_col      (req_right_col),
      .empty              (empty),
      .pop                (pop),
      .rsp_rect_magnitude (rsp_rect_magnitude),
      .rsp_query_status   (rsp_query_status)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned grid_side();
      if (side_reg == 0) return 1;
      if (side_reg > GRID_MAX) return GRID_MAX;
      return side_reg;
   endfunction

   // Row 0 and column 0 stand for the empty border and read as zero.
   function automatic sum_type prefix_at(int unsigned row, int unsigned col);
      if (row == 0 || col == 0) return '0;
      return prefix_sums[(row - 1) * GRID_MAX + (col - 1)];
   endfunction

   function automatic void restart_grid();
      next_row    = 1;
      next_col    = 1;
      run_sum     = '0;
      grid_loaded = 1'b0;
   endfunction

   task automatic predict_request(logic kind, logic [CELL_W-1:0] cell_data,
                                  coord_type t, coord_type l,
                                  coord_type b, coord_type r);
      int unsigned     side;
      sum_type         value;
      sum_type         total;
      rect_result_type res;
      side = grid_side();
      if (kind == REQ_LOAD) begin
         if (grid_loaded) return;
         value = {{(SUM_W - CELL_W){cell_data[CELL_W-1]}}, cell_data};
         if (((next_row + next_col) % 2) == 0) value = -value;
         value = value + prefix_at(next_row - 1, next_col) + run_sum
                 - prefix_at(next_row - 1, next_col - 1);
         prefix_sums[(next_row - 1) * GRID_MAX + (next_col - 1)] = value;
         run_sum = value;
         if (next_col >= side) begin
            next_col = 1;
            run_sum  = '0;
            if (next_row >= side) begin
               next_row    = 1;
               grid_loaded = 1'b1;
            end else begin
               next_row++;
            end
         end else begin
            next_col++;
         end
      end else begin
         if (!grid_loaded || t == 0 || l == 0 || t > b || l > r
             || b > side || r > side) begin
            res.magnitude = '0;
            res.status    = STATUS_BAD;
         end else begin
            total = prefix_at(b, r) - prefix_at(t - 1, r) - prefix_at(b, l - 1)
                    + prefix_at(t - 1, l - 1);
            res.magnitude = total[SUM_W-1] ? -total : total;
            res.status    = STATUS_OK;
         end
         expected_rects = {expected_rects, res};
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic send_request(logic kind, logic [CELL_W-1:0] cell_data,
                               coord_type t, coord_type l,
                               coord_type b, coord_type r);
      int unsigned gap;
      gap = 0;
      if (tx_idle_en && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push           <= 1'b1;
      req_type       <= kind;
      req_cell_value <= cell_data;
      req_top_row    <= t;
      req_left_col   <= l;
      req_bottom_row <= b;
      req_right_col  <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_request(kind, cell_data, t, l, b, r);
   endtask

   function automatic coord_type rand_coord();
      return COORD_W'($urandom_range(0, 1023));
   endfunction

   task automatic send_load(logic [CELL_W-1:0] cell_data);
      send_request(REQ_LOAD, cell_data, rand_coord(), rand_coord(),
                   rand_coord(), rand_coord());
   endtask

   task automatic send_query(coord_type t, coord_type l, coord_type b, coord_type r);
      send_request(REQ_QUERY, $urandom(), t, l, b, r);
   endtask

   // Pushes stop while waiting, so a held request is never taken twice.
   task automatic wait_for_results();
      push <= 1'b0;
      while (expected_rects.size() != 0) @(posedge clock);
   endtask

   // Loads leave nothing to wait for, so the back end gets extra time to drain.
   task automatic write_side(coord_type value);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      side_reg = value;
      restart_grid();
   endtask

   function automatic logic [CELL_W-1:0] pick_cell();
      case ($urandom_range(0, 7))
         0:       return CELL_MIN;
         1:       return CELL_MAX;
         2:       return $urandom_range(0, 31) - 16;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   task automatic load_grid(int unsigned cells);
      repeat (cells) send_load(pick_cell());
   endtask

   // Mostly well-formed rectangles, with some malformed corners mixed in.
   task automatic random_queries(int unsigned count, int unsigned side);
      coord_type t, l, b, r;
      repeat (count) begin
         t = COORD_W'($urandom_range(1, side));
         b = COORD_W'($urandom_range(t, side));
         l = COORD_W'($urandom_range(1, side));
         r = COORD_W'($urandom_range(l, side));
         case ($urandom_range(0, 9))
            0: begin
               t = rand_coord();
               l = rand_coord();
               b = rand_coord();
               r = rand_coord();
            end
            1: if ($urandom_range(0, 1)) t = 0; else l = 0;
            2: if ($urandom_range(0, 1)) b = COORD_W'(side + 1);
               else r = COORD_W'(side + 1);
            3: if (t != b) {t, b} = {b, t}; else {l, r} = {r, l};
            default: ;
         endcase
         send_query(t, l, b, r);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_defaults();
      send_query(1, 1, 1, 1);        // nothing loaded yet
      send_load(CELL_MIN);           // side 1 after reset, one cell fills it
      send_query(1, 1, 1, 1);
      send_query(0, 1, 1, 1);
      send_load(CELL_MAX);           // grid already full, dropped
      send_query(1, 1, 1, 1);
   endtask

   task automatic test_side_limits();
      write_side(0);
      send_load(CELL_MAX);
      send_query(1, 1, 1, 1);
      send_query(2, 2, 2, 2);
      write_side(1023);
      send_load('0);
      send_load(32'hffff_ffff);
      send_query(1, 1, 1, 1);
      send_query(513, 513, 513, 513);
      write_side(512);
      send_load(CELL_MIN);
      send_query(512, 512, 512, 512);
   endtask

   task automatic test_small_grid_cases();
      write_side(3);
      send_load(CELL_MAX);
      send_load(CELL_MIN);
      // Rewriting the side in the middle of a pass starts loading over.
      write_side(2);
      send_load(CELL_MIN);
      send_load(CELL_MAX);
      send_load('0);
      send_load(32'hffff_ffff);
      send_query(1, 1, 2, 2);
      send_query(2, 1, 1, 2);
      send_query(1, 2, 2, 1);
      send_query(1, 1, 3, 2);
      send_query(1, 0, 2, 2);
      send_query(1023, 1023, 1023, 1023);
   endtask

   task automatic test_backpressure();
      write_side(4);
      load_grid(16);
      tx_idle_en  = 1'b0;
      hold_wanted <= 1'b1;
      random_queries(24, 4);
      tx_idle_en  = 1'b1;
   endtask

   task automatic test_sender_pause();
      random_queries(6, 4);
      wait_for_results();
      random_queries(6, 4);
   endtask

   task automatic test_random_grids(int unsigned target);
      int unsigned done;
      int unsigned side;
      int unsigned cells;
      int unsigned count;
      coord_type   raw;
      done = 0;
      while (done < target) begin
         case ($urandom_range(0, 19))
            0:       raw = 0;
            1:       raw = COORD_W'($urandom_range(9, 16));
            default: raw = COORD_W'($urandom_range(1, 8));
         endcase
         side = (raw == 0) ? 1 : raw;
         write_side(raw);
         if ($urandom_range(0, 3) == 0) begin
            random_queries(1, side);
            done++;
         end
         if ($urandom_range(0, 9) == 0) begin
            // Broken pass: stop part way and query the unfinished grid.
            cells = $urandom_range(0, side * side - 1);
            load_grid(cells);
            random_queries(2, side);
            done += cells + 2;
         end else begin
            load_grid(side * side);
            if ($urandom_range(0, 4) == 0) send_load(pick_cell());
            count = $urandom_range(4, 16);
            random_queries(count, side);
            done += side * side + count;
         end
      end
   endtask

   task automatic test_quiet_finish();
      tx_idle_en = 1'b0;
      rx_idle_en <= 1'b0;
      write_side(5);
      load_grid(25);
      random_queries(40, 5);
   endtask

   initial begin : stimulus
      side_reg = 1;
      restart_grid();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_side_limits();
      test_small_grid_cases();
      test_backpressure();
      test_sender_pause();
      test_random_grids(430);
      test_quiet_finish();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side: pops with random stalls and checks each result.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      rect_result_type want;
      int              stall_left;
      int              hold_left;
      bit              hold_taken;
      if (reset) begin
         pop        <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_taken = 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_rects.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d/%0b",
                        $time, rsp_rect_magnitude, rsp_query_status);
               failures++;
            end else begin
               want = expected_rects.pop_front();
               if (rsp_rect_magnitude !== want.magnitude) begin
                  $display("%0t: rect_magnitude mismatch, expected %0d, actual %0d",
                           $time, want.magnitude, rsp_rect_magnitude);
                  failures++;
               end
               if (rsp_query_status !== want.status) begin
                  $display("%0t: query_status mismatch, expected %0b, actual %0b",
                           $time, want.status, rsp_query_status);
                  failures++;
               end
            end
         end
         if (hold_wanted && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            pop <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Ends the run when neither side has moved for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
